// ===== rtl/core/obbfc_pkg.sv =====
// Shared types and constants of the OBB frustum culling block.
// No dependencies; imported by the core and its checker.
package obbfc_pkg;

    // Plane bank
    localparam int NUM_PLANES  = 6;
    localparam int SIDE_PLANES = 4;
    localparam int NUM_CORNERS = 4;

    // Register file: 64-bit registers at byte address 8*index
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_4   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_5   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE = 3'd6;

    // Plane register layout
    localparam int NORM_W  = 12;
    localparam int DIST_W  = 28;
    localparam int D_SHIFT = 10;

    typedef struct packed {
        logic signed [DIST_W-1:0] offset;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } plane_t;

    // Clock edges from an accepted beat to the sampled result strobe
    localparam int PIPE_DEPTH = 5;

endpackage

// ===== rtl/core/obb_frustum_cull.sv =====
// OBB versus frustum culling core: five-stage pipeline and plane register file.
// Depends on obbfc_pkg.
//
// Usage:
//   Input channel: drive the box center and three half axes and raise start.
//   A beat is taken at every rising edge with start high and busy low; busy
//   is always low, so one box enters per clock.
//   Result channel: done is high for one cycle with culled valid; the
//   accepted beat passes vld1_reg to vld4_reg and done_reg. There is
//   no back-pressure; the receiver must take every result as it appears.
//   Throughput is one box per cycle, set by the fully parallel multiplier
//   bank (72 corner and 18 center products, one per plane, corner and axis).
//   Stages: corner sums, products, dot sums with magnitude, corner maximum
//   pairs, final maximum with plane compare and OR.
//   Configuration: APB port, plane_0..plane_5 at 0x00..0x28, fast_mode at
//   0x30, 64-bit data, pready always high. Write only while no box is in flight.
//   Reset: all planes and fast_mode clear to zero, pipeline valids clear; with
//   zero planes every box reads as culled.
module obb_frustum_cull
    import obbfc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // box input
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic signed [COORD_WIDTH-1:0] axis0_x,
    input  logic signed [COORD_WIDTH-1:0] axis0_y,
    input  logic signed [COORD_WIDTH-1:0] axis0_z,
    input  logic signed [COORD_WIDTH-1:0] axis1_x,
    input  logic signed [COORD_WIDTH-1:0] axis1_y,
    input  logic signed [COORD_WIDTH-1:0] axis1_z,
    input  logic signed [COORD_WIDTH-1:0] axis2_x,
    input  logic signed [COORD_WIDTH-1:0] axis2_y,
    input  logic signed [COORD_WIDTH-1:0] axis2_z,
    // result
    output logic                          done,
    output logic                          culled,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_W-1:0]         paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready
);

    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 2;                    // corner vector component
    localparam int PW  = VW + NORM_W;              // corner product
    localparam int CPW = W + NORM_W;               // center product
    localparam int RW  = PW + 2;                   // corner dot / radius
    localparam int SW  = ((CPW + 2) > (DIST_W + D_SHIFT) ? (CPW + 2)
                                                         : (DIST_W + D_SHIFT)) + 1;
    localparam int TW  = (SW > RW ? SW : RW) + 1;  // s + r compare

    // ---------------- configuration registers ----------------
    plane_t                 plane_reg [NUM_PLANES];
    logic                   fast_reg;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic                   cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write a plane or the mode bit; other indexes drop the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                plane_reg[p] <= '0;
            end
            fast_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (cfg_idx == CFG_IDX_W'(p))
                begin
                    plane_reg[p] <= plane_t'(pwdata);
                end
            end
            if (cfg_idx == REG_FAST_MODE)
            begin
                fast_reg <= pwdata[0];
            end
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (cfg_idx)
            REG_PLANE_0:   prdata = plane_reg[0];
            REG_PLANE_1:   prdata = plane_reg[1];
            REG_PLANE_2:   prdata = plane_reg[2];
            REG_PLANE_3:   prdata = plane_reg[3];
            REG_PLANE_4:   prdata = plane_reg[4];
            REG_PLANE_5:   prdata = plane_reg[5];
            REG_FAST_MODE: prdata = {{(CFG_DATA_W-1){1'b0}}, fast_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- stage 1: corner vectors ----------------
    logic signed [W-1:0]  ax [3][3];
    logic signed [W-1:0]  cin [3];
    logic signed [VW-1:0] corner_next [NUM_CORNERS][3];
    logic signed [VW-1:0] corner_reg  [NUM_CORNERS][3];
    logic signed [W-1:0]  center1_reg [3];
    logic                 vld1_reg;

    assign ax[0] = '{axis0_x, axis0_y, axis0_z};
    assign ax[1] = '{axis1_x, axis1_y, axis1_z};
    assign ax[2] = '{axis2_x, axis2_y, axis2_z};
    assign cin   = '{center_x, center_y, center_z};

    // Form a0+a1+a2, -a0+a1+a2, a0-a1+a2, a0+a1-a2 per component
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            corner_next[0][j] = VW'(ax[0][j]) + VW'(ax[1][j]) + VW'(ax[2][j]);
            corner_next[1][j] = -VW'(ax[0][j]) + VW'(ax[1][j]) + VW'(ax[2][j]);
            corner_next[2][j] = VW'(ax[0][j]) - VW'(ax[1][j]) + VW'(ax[2][j]);
            corner_next[3][j] = VW'(ax[0][j]) + VW'(ax[1][j]) - VW'(ax[2][j]);
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [NORM_W-1:0] nrm [NUM_PLANES][3];
    logic signed [PW-1:0]     prod_next  [NUM_PLANES][NUM_CORNERS][3];
    logic signed [PW-1:0]     prod_reg   [NUM_PLANES][NUM_CORNERS][3];
    logic signed [CPW-1:0]    cprod_next [NUM_PLANES][3];
    logic signed [CPW-1:0]    cprod_reg  [NUM_PLANES][3];
    logic                     vld2_reg;

    // Multiply every corner and the center by each plane normal
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            nrm[p][0] = plane_reg[p].nx;
            nrm[p][1] = plane_reg[p].ny;
            nrm[p][2] = plane_reg[p].nz;
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < NUM_CORNERS; k++)
                begin
                    prod_next[p][k][j] = PW'(corner_reg[k][j]) * PW'(nrm[p][j]);
                end
                cprod_next[p][j] = CPW'(center1_reg[j]) * CPW'(nrm[p][j]);
            end
        end
    end

    // ---------------- stage 3: dot sums, magnitude, distance ----------------
    logic signed [RW-1:0] dot_v     [NUM_PLANES][NUM_CORNERS];
    logic signed [RW-1:0] rad_next  [NUM_PLANES][NUM_CORNERS];
    logic signed [RW-1:0] rad_reg   [NUM_PLANES][NUM_CORNERS];
    logic signed [SW-1:0] dist_next [NUM_PLANES];
    logic signed [SW-1:0] dist3_reg [NUM_PLANES];
    logic                 vld3_reg;

    // Sum products, take magnitudes, add the scaled offset to the center dot
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                dot_v[p][k] = RW'(prod_reg[p][k][0]) + RW'(prod_reg[p][k][1])
                            + RW'(prod_reg[p][k][2]);
                rad_next[p][k] = (dot_v[p][k] < 0) ? -dot_v[p][k] : dot_v[p][k];
            end
            dist_next[p] = SW'(cprod_reg[p][0]) + SW'(cprod_reg[p][1])
                         + SW'(cprod_reg[p][2])
                         + SW'($signed({plane_reg[p].offset, {D_SHIFT{1'b0}}}));
        end
    end

    // ---------------- stage 4: pairwise maximum ----------------
    logic signed [RW-1:0] rmax_next [NUM_PLANES][2];
    logic signed [RW-1:0] rmax_reg  [NUM_PLANES][2];
    logic signed [SW-1:0] dist4_reg [NUM_PLANES];
    logic                 vld4_reg;

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            rmax_next[p][0] = (rad_reg[p][1] > rad_reg[p][0]) ? rad_reg[p][1] : rad_reg[p][0];
            rmax_next[p][1] = (rad_reg[p][3] > rad_reg[p][2]) ? rad_reg[p][3] : rad_reg[p][2];
        end
    end

    // ---------------- stage 5: plane test and combine ----------------
    logic signed [RW-1:0]  rfin [NUM_PLANES];
    logic signed [TW-1:0]  slack [NUM_PLANES];
    logic [NUM_PLANES-1:0] outside;
    logic                  culled_next;
    logic                  culled_reg;
    logic                  done_reg;

    // Outside when s + r <= 0; drop planes 4 and 5 in fast mode
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            rfin[p]    = (rmax_reg[p][1] > rmax_reg[p][0]) ? rmax_reg[p][1] : rmax_reg[p][0];
            slack[p]   = TW'(dist4_reg[p]) + TW'(rfin[p]);
            outside[p] = (slack[p] <= 0);
        end
        culled_next = (|outside[SIDE_PLANES-1:0])
                    || (!fast_reg && (|outside[NUM_PLANES-1:SIDE_PLANES]));
    end

    // Advance valids every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            done_reg <= vld4_reg;
        end
    end

    // Advance payload with no reset
    always_ff @(posedge clk)
    begin
        corner_reg  <= corner_next;
        center1_reg <= cin;
        prod_reg    <= prod_next;
        cprod_reg   <= cprod_next;
        rad_reg     <= rad_next;
        dist3_reg   <= dist_next;
        rmax_reg    <= rmax_next;
        dist4_reg   <= dist3_reg;
        culled_reg  <= culled_next;
    end

    assign done   = done_reg;
    assign culled = culled_reg;

endmodule

// ===== rtl/core/obbfc_checker.sv =====
// Port-level checker for the OBB frustum culling core, with its bind.
// Depends on obbfc_pkg and binds into obb_frustum_cull.
module obbfc_checker
    import obbfc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic                  culled,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready
);

    localparam int CW = $clog2(PIPE_DEPTH + 1);

    logic [CW-1:0]        warm_reg;
    logic                 touched_reg;
    logic                 plane_wr;
    logic [CFG_IDX_W-1:0] idx;

    assign idx      = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
    assign plane_wr = psel && penable && pwrite && pready
                   && (idx <= REG_PLANE_5);

    // Count cycles out of reset; note the first plane write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg    <= '0;
            touched_reg <= 1'b0;
        end
        else
        begin
            if (warm_reg != CW'(PIPE_DEPTH))
            begin
                warm_reg <= warm_reg + 1'b1;
            end
            if (plane_wr)
            begin
                touched_reg <= 1'b1;
            end
        end
    end

    // One result beat for each accepted box
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == CW'(PIPE_DEPTH)) |-> (done == $past(start && !busy, PIPE_DEPTH)))
        else $error("result strobe does not match accepted beats");

    // Zero planes after reset cull every box
    a_reset_culls: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !touched_reg) |-> culled)
        else $error("box not culled with reset planes");

    // A write to plane 0 reads back while plane 0 stays addressed
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && idx == REG_PLANE_0)
        |=> (idx != REG_PLANE_0 || prdata == $past(pwdata)))
        else $error("plane 0 readback mismatch");

    // Input side never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised");

endmodule

bind obb_frustum_cull obbfc_checker u_obbfc_checker (.*);
